// ----- rtl/pdpl_pkg.sv -----
// ----------------------------------------------------------------------------
// pdpl_pkg: USB PD protocol layer shared types and constants
// Event codes, transmit phases, header decode constants and the structs that
// pass state, event beats and results between the step logic and the top level.
// ----------------------------------------------------------------------------
package pdpl_pkg;

	// event codes on the command field
	typedef enum logic [1:0] {
		CMD_TX_REQUEST  = 2'd0,
		CMD_PHY_TX_DONE = 2'd1,
		CMD_PHY_RESP    = 2'd2,
		CMD_RX_MESSAGE  = 2'd3
	} cmd_t;

	// transmit phase
	typedef enum logic [1:0] {
		PH_WAIT     = 2'd0,
		PH_PHYDONE  = 2'd1,
		PH_TXDONE   = 2'd2,
		PH_RESPONSE = 2'd3
	} phase_t;

	// configuration register indexes
	localparam logic CFG_PD_REV2     = 1'b0;
	localparam logic CFG_RETRY_COUNT = 1'b1;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 3;
	localparam int unsigned ID_W       = 3;
	localparam int unsigned HDR_W      = 16;

	localparam logic [ID_W-1:0] RETRY_COUNT_RST = 3'd3;

	// control message Soft_Reset: type field, zero data objects, extended clear
	localparam logic [HDR_W-1:0] HDR_SOFT_RESET_MASK = 16'hF01F;
	localparam logic [HDR_W-1:0] HDR_SOFT_RESET_VAL  = 16'd13;
	localparam int unsigned      HDR_ID_LSB          = 9;

	typedef struct packed {
		phase_t          phase;
		logic [ID_W-1:0] retry_cnt;
		logic [ID_W-1:0] tx_id;
		logic            rx_id_valid;
		logic [ID_W-1:0] rx_id;
		logic            sent;
		logic            rcvd;
	} pd_state_t;

	typedef struct packed {
		cmd_t             command;
		logic             soft_reset_request;
		logic             ams_pending;
		logic             expects_goodcrc;
		logic             bist_active;
		logic             bist_remaining;
		logic             response_ok;
		logic [ID_W-1:0]  goodcrc_id;
		logic [HDR_W-1:0] rx_header;
		logic             rx_sop_prime;
		logic             sop_prime_expected;
	} pd_event_t;

	typedef struct packed {
		logic [ID_W-1:0] message_id;
		logic            transmit;
		logic            retransmit;
		logic            start_receive_timer;
		logic            notify_policy;
		logic            sent_ok;
		logic            received;
		logic            duplicate_dropped;
		logic            transmit_error;
	} pd_result_t;

endpackage

// ----- rtl/pdpl_step.sv -----
// ----------------------------------------------------------------------------
// pdpl_step: protocol layer next-state logic
// Takes one event and the current sequencer state and produces the next state
// and the result of that event. Purely combinational.
// ----------------------------------------------------------------------------
module pdpl_step (
	input  pdpl_pkg::pd_state_t                  cur,
	input  pdpl_pkg::pd_event_t                  ev,
	input  logic                                 pd_rev2,
	input  logic [pdpl_pkg::ID_W-1:0]            retry_count,
	output pdpl_pkg::pd_state_t                  nxt,
	output pdpl_pkg::pd_result_t                 res
);
	import pdpl_pkg::*;

	logic [ID_W-1:0] limit;
	logic [ID_W-1:0] hdr_id;
	logic            hdr_soft_reset;
	logic            rx_take;

	assign limit = pd_rev2 ? retry_count :
		((retry_count != '0) ? retry_count - ID_W'(1) : '0);
	assign hdr_id         = ev.rx_header[HDR_ID_LSB +: ID_W];
	assign hdr_soft_reset = (ev.rx_header & HDR_SOFT_RESET_MASK) == HDR_SOFT_RESET_VAL;
	assign rx_take        = !(ev.rx_sop_prime && !ev.sop_prime_expected);

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (ev.command)
			CMD_TX_REQUEST: begin
				if (cur.phase == PH_WAIT) begin
					nxt.retry_cnt = '0;
					nxt.sent      = 1'b0;
					if (ev.soft_reset_request) begin
						nxt.tx_id       = '0;
						nxt.rx_id_valid = 1'b0;
						nxt.rx_id       = '0;
					end
					// collision avoidance: hand back to policy, stay in wait
					if (ev.ams_pending) begin
						res.notify_policy = 1'b1;
					end else begin
						res.transmit = 1'b1;
						nxt.phase    = ev.expects_goodcrc ? PH_TXDONE : PH_PHYDONE;
					end
				end
			end
			CMD_PHY_TX_DONE: begin
				if (cur.phase == PH_PHYDONE) begin
					if (ev.bist_active && ev.bist_remaining) begin
						res.transmit = 1'b1;
					end else begin
						nxt.phase         = PH_WAIT;
						res.notify_policy = ev.bist_active;
					end
				end else if (cur.phase == PH_TXDONE) begin
					res.start_receive_timer = 1'b1;
					nxt.phase               = PH_RESPONSE;
				end
			end
			CMD_PHY_RESP: begin
				if (cur.phase == PH_RESPONSE) begin
					if (ev.response_ok && ev.goodcrc_id == cur.tx_id) begin
						nxt.tx_id         = cur.tx_id + ID_W'(1);
						res.notify_policy = 1'b1;
						nxt.sent          = 1'b1;
						nxt.rcvd          = 1'b0;
						nxt.phase         = PH_WAIT;
					end else begin
						nxt.sent = 1'b0;
						if (cur.retry_cnt >= limit) begin
							nxt.tx_id          = cur.tx_id + ID_W'(1);
							res.notify_policy  = 1'b1;
							res.transmit_error = 1'b1;
							nxt.phase          = PH_WAIT;
						end else begin
							res.retransmit = 1'b1;
							nxt.retry_cnt  = cur.retry_cnt + ID_W'(1);
							nxt.phase      = PH_TXDONE;
						end
					end
				end
			end
			CMD_RX_MESSAGE: begin
				if (rx_take) begin
					// soft reset clears IDs before the duplicate check
					if (hdr_soft_reset) begin
						nxt.tx_id       = '0;
						nxt.rx_id_valid = 1'b0;
						nxt.rx_id       = '0;
					end
					if (nxt.rx_id_valid && nxt.rx_id == hdr_id) begin
						res.duplicate_dropped = 1'b1;
					end else begin
						nxt.rx_id         = hdr_id;
						nxt.rx_id_valid   = 1'b1;
						nxt.phase         = PH_WAIT;
						nxt.rcvd          = 1'b1;
						nxt.sent          = 1'b0;
						res.notify_policy = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		res.message_id = nxt.tx_id;
		res.sent_ok    = nxt.sent;
		res.received   = nxt.rcvd;
	end

endmodule

// ----- rtl/pd_protocol_layer_tx_rx.sv -----
// ----------------------------------------------------------------------------
// pd_protocol_layer_tx_rx: USB PD protocol layer transmit/receive sequencer
// Sequences message transmission and retries, tracks message IDs and drops
// duplicate receptions.
// ----------------------------------------------------------------------------
// Takes one event beat per clock while in_ready is high and returns exactly
// one result beat per event, in the cycle after acceptance. The sequencer
// state is updated at the acceptance edge and the result lands in a single
// output register; in_ready is high whenever that register is empty or being
// drained in the same cycle, so with out_ready held high the block sustains
// one event per cycle. The user must set retry limit and revision through
// the write port while no event is in flight; the block does not enforce it.
module pd_protocol_layer_tx_rx (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [pdpl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pdpl_pkg::CFG_DATA_W-1:0]       cfg_data,
	// event channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            command,
	input  logic                                  soft_reset_request,
	input  logic                                  ams_pending,
	input  logic                                  expects_goodcrc,
	input  logic                                  bist_active,
	input  logic                                  bist_remaining,
	input  logic                                  response_ok,
	input  logic [pdpl_pkg::ID_W-1:0]             goodcrc_id,
	input  logic [pdpl_pkg::HDR_W-1:0]            rx_header,
	input  logic                                  rx_sop_prime,
	input  logic                                  sop_prime_expected,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [pdpl_pkg::ID_W-1:0]             message_id,
	output logic                                  transmit,
	output logic                                  retransmit,
	output logic                                  start_receive_timer,
	output logic                                  notify_policy,
	output logic                                  sent_ok,
	output logic                                  received,
	output logic                                  duplicate_dropped,
	output logic                                  transmit_error
);
	import pdpl_pkg::*;

	logic            pd_rev2_q;
	logic [ID_W-1:0] retry_count_q;
	pd_state_t       state_q;
	pd_state_t       state_nxt;
	pd_event_t       ev;
	pd_result_t      res_nxt;
	pd_result_t      res_q;
	logic            out_valid_q;
	logic            in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign ev.command            = cmd_t'(command);
	assign ev.soft_reset_request = soft_reset_request;
	assign ev.ams_pending        = ams_pending;
	assign ev.expects_goodcrc    = expects_goodcrc;
	assign ev.bist_active        = bist_active;
	assign ev.bist_remaining     = bist_remaining;
	assign ev.response_ok        = response_ok;
	assign ev.goodcrc_id         = goodcrc_id;
	assign ev.rx_header          = rx_header;
	assign ev.rx_sop_prime       = rx_sop_prime;
	assign ev.sop_prime_expected = sop_prime_expected;

	pdpl_step u_step (
		.cur         (state_q),
		.ev          (ev),
		.pd_rev2     (pd_rev2_q),
		.retry_count (retry_count_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_rev2_q     <= 1'b0;
			retry_count_q <= RETRY_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PD_REV2:     pd_rev2_q     <= cfg_data[0];
				CFG_RETRY_COUNT: retry_count_q <= cfg_data[ID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_WAIT, default: '0};
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid           = out_valid_q;
	assign message_id          = res_q.message_id;
	assign transmit            = res_q.transmit;
	assign retransmit          = res_q.retransmit;
	assign start_receive_timer = res_q.start_receive_timer;
	assign notify_policy       = res_q.notify_policy;
	assign sent_ok             = res_q.sent_ok;
	assign received            = res_q.received;
	assign duplicate_dropped   = res_q.duplicate_dropped;
	assign transmit_error      = res_q.transmit_error;

	// a failed transmission always reaches the policy engine
	a_err_notifies: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.transmit_error |-> res_q.notify_policy)
		else $error("transmit error without policy notification");

	// acknowledged-send and received flags clear each other
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.sent && state_q.rcvd))
		else $error("sent and received flags both set");

	// the received flag may still be set from the earlier copy of the message
	a_dup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.duplicate_dropped |->
			!res_q.notify_policy && !res_q.transmit)
		else $error("dropped duplicate produced activity");

	a_retx_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.retransmit |-> state_q.phase == PH_TXDONE)
		else $error("retransmit without waiting for tx done");

	a_timer_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.start_receive_timer |-> state_q.phase == PH_RESPONSE)
		else $error("receive timer started outside response phase");

	// the register drains only through a completed beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(state_q))
		else $error("result or state changed while stalled");

endmodule

// ----- bench/tb_pd_protocol_layer_tx_rx.sv -----
// ----------------------------------------------------------------------------
// tb_pd_protocol_layer_tx_rx: self-checking bench for the PD protocol layer
// Drives event beats (transmit requests, PHY done, PHY responses, received
// headers) with random gaps and output stalls. Every accepted beat runs
// through a local sequencer model whose outcome is checked field by field
// against the result beat. Retry settings are swept between idle phases.
// ----------------------------------------------------------------------------
module tb_pd_protocol_layer_tx_rx;
	import pdpl_pkg::*;

	localparam int unsigned RUN_LIMIT  = 3_000_000;
	localparam int unsigned N_PLAN     = 6;
	localparam int unsigned PER_PHASE  = 85;
	localparam int unsigned MAX_PRINTS = 40;
	localparam int unsigned EV_W       = $bits(pd_event_t);

	// how the GoodCRC ID of a queued response is filled in at drive time
	typedef enum logic [1:0] {
		CRC_ID_RANDOM,
		CRC_ID_MATCH,
		CRC_ID_STALE
	} crc_id_sel_t;

	typedef struct {
		pd_event_t   ev;
		crc_id_sel_t id_sel;
		bit          rx_repeat;
	} queued_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	pd_event_t             ev_drv = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [ID_W-1:0]       message_id;
	logic                  transmit, retransmit, start_receive_timer, notify_policy;
	logic                  sent_ok, received, duplicate_dropped, transmit_error;

	queued_event_t event_q[$];
	pd_result_t    outcome_q[$];
	logic          ev_fire = 1'b0;
	int            ev_gap = 0;
	int            stall_left = 0;
	bit            no_idle = 1'b0;
	int            queued_cnt = 0;
	int            beats_checked = 0;
	int            fail_cnt = 0;

	// sequencer model state
	phase_t          m_phase = PH_WAIT;
	logic [ID_W-1:0] m_retries = '0;
	logic [ID_W-1:0] m_tx_id = '0;
	logic [ID_W-1:0] m_rx_id = '0;
	logic            m_rx_vld = 1'b0;
	logic            m_sent = 1'b0;
	logic            m_rcvd = 1'b0;
	logic            m_rev2 = 1'b0;
	logic [ID_W-1:0] m_retry_cfg = RETRY_COUNT_RST;

	int n_sent = 0, n_retx = 0, n_err = 0, n_dup = 0, n_rcvd = 0;

	pd_protocol_layer_tx_rx DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (ev_drv.command),
		.soft_reset_request (ev_drv.soft_reset_request),
		.ams_pending        (ev_drv.ams_pending),
		.expects_goodcrc    (ev_drv.expects_goodcrc),
		.bist_active        (ev_drv.bist_active),
		.bist_remaining     (ev_drv.bist_remaining),
		.response_ok        (ev_drv.response_ok),
		.goodcrc_id         (ev_drv.goodcrc_id),
		.rx_header          (ev_drv.rx_header),
		.rx_sop_prime       (ev_drv.rx_sop_prime),
		.sop_prime_expected (ev_drv.sop_prime_expected),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.message_id         (message_id),
		.transmit           (transmit),
		.retransmit         (retransmit),
		.start_receive_timer(start_receive_timer),
		.notify_policy      (notify_policy),
		.sent_ok            (sent_ok),
		.received           (received),
		.duplicate_dropped  (duplicate_dropped),
		.transmit_error     (transmit_error)
	);

	always #5 clk = ~clk;

	initial begin
		#(RUN_LIMIT);
		$display("timeout: %0d outcomes still pending", outcome_q.size());
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (fail_cnt < MAX_PRINTS)
			$display("[%0t] MISMATCH beat %0d: %s", $time, beats_checked, msg);
		fail_cnt++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// one event through the sequencer model; updates model state
	task automatic sequence_event(input pd_event_t ev, output pd_result_t r);
		logic [ID_W-1:0] lim;
		logic [ID_W-1:0] rid;
		r = '0;
		case (ev.command)
			CMD_TX_REQUEST: if (m_phase == PH_WAIT) begin
				m_retries = '0;
				m_sent = 1'b0;
				if (ev.soft_reset_request) begin
					m_tx_id = '0;
					m_rx_vld = 1'b0;
					m_rx_id = '0;
				end
				if (ev.ams_pending)
					r.notify_policy = 1'b1;
				else begin
					r.transmit = 1'b1;
					m_phase = ev.expects_goodcrc ? PH_TXDONE : PH_PHYDONE;
				end
			end
			CMD_PHY_TX_DONE: if (m_phase == PH_PHYDONE) begin
				if (ev.bist_active && ev.bist_remaining)
					r.transmit = 1'b1;
				else begin
					r.notify_policy = ev.bist_active;
					m_phase = PH_WAIT;
				end
			end else if (m_phase == PH_TXDONE) begin
				r.start_receive_timer = 1'b1;
				m_phase = PH_RESPONSE;
			end
			CMD_PHY_RESP: if (m_phase == PH_RESPONSE) begin
				if (ev.response_ok && ev.goodcrc_id == m_tx_id) begin
					m_tx_id = m_tx_id + 1'b1;
					r.notify_policy = 1'b1;
					m_sent = 1'b1;
					m_rcvd = 1'b0;
					m_phase = PH_WAIT;
					n_sent++;
				end else begin
					// rev 3.0 allows one retry less, floored at zero
					if (m_rev2)
						lim = m_retry_cfg;
					else
						lim = (m_retry_cfg != '0) ? m_retry_cfg - 1'b1 : '0;
					if (m_retries >= lim) begin
						m_tx_id = m_tx_id + 1'b1;
						r.notify_policy = 1'b1;
						r.transmit_error = 1'b1;
						m_phase = PH_WAIT;
						n_err++;
					end else begin
						r.retransmit = 1'b1;
						m_retries = m_retries + 1'b1;
						m_phase = PH_TXDONE;
						n_retx++;
					end
					m_sent = 1'b0;
				end
			end
			default: if (!(ev.rx_sop_prime && !ev.sop_prime_expected)) begin
				rid = ev.rx_header[HDR_ID_LSB +: ID_W];
				if ((ev.rx_header & HDR_SOFT_RESET_MASK) == HDR_SOFT_RESET_VAL) begin
					m_tx_id = '0;
					m_rx_vld = 1'b0;
					m_rx_id = '0;
				end
				if (m_rx_vld && m_rx_id == rid) begin
					r.duplicate_dropped = 1'b1;
					n_dup++;
				end else begin
					m_rx_id = rid;
					m_rx_vld = 1'b1;
					m_phase = PH_WAIT;
					m_rcvd = 1'b1;
					m_sent = 1'b0;
					r.notify_policy = 1'b1;
					n_rcvd++;
				end
			end
		endcase
		r.message_id = m_tx_id;
		r.sent_ok = m_sent;
		r.received = m_rcvd;
	endtask

	// result beats checked first, then the event beat taken at this edge
	always @(posedge clk) begin : result_mon
		pd_result_t got, want;
		ev_fire <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			got = '{message_id, transmit, retransmit, start_receive_timer, notify_policy,
				sent_ok, received, duplicate_dropped, transmit_error};
			if (outcome_q.size() == 0)
				report_mismatch("result beat with no event outstanding");
			else begin
				want = outcome_q.pop_front();
				check_field("message_id", got.message_id, want.message_id);
				check_field("transmit", got.transmit, want.transmit);
				check_field("retransmit", got.retransmit, want.retransmit);
				check_field("start_receive_timer", got.start_receive_timer,
					want.start_receive_timer);
				check_field("notify_policy", got.notify_policy, want.notify_policy);
				check_field("sent_ok", got.sent_ok, want.sent_ok);
				check_field("received", got.received, want.received);
				check_field("duplicate_dropped", got.duplicate_dropped,
					want.duplicate_dropped);
				check_field("transmit_error", got.transmit_error, want.transmit_error);
			end
			beats_checked++;
		end
		if (arst_n && in_valid && in_ready) begin
			sequence_event(ev_drv, want);
			outcome_q.push_back(want);
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic bit rbit();
		return 1'($urandom);
	endfunction

	// IDs are filled in here: the model is current once the previous beat is taken
	always @(negedge clk) begin : ev_driver
		queued_event_t it;
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || ev_fire) begin
			if (ev_gap > 0) begin
				in_valid <= 1'b0;
				ev_gap <= ev_gap - 1;
			end else if (event_q.size() != 0) begin
				it = event_q.pop_front();
				if (it.id_sel == CRC_ID_MATCH)
					it.ev.goodcrc_id = m_tx_id;
				else if (it.id_sel == CRC_ID_STALE)
					it.ev.goodcrc_id = m_tx_id + 1'b1;
				if (it.rx_repeat)
					it.ev.rx_header[HDR_ID_LSB +: ID_W] = m_rx_id;
				ev_drv <= it.ev;
				in_valid <= 1'b1;
				ev_gap <= no_idle ? 0 : idle_len();
			end else
				in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin : sink_driver
		if (!arst_n)
			out_ready <= 1'b0;
		else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left <= no_idle ? 0 : idle_len();
		end
	end

	function automatic pd_event_t rand_event();
		logic [EV_W-1:0] raw;
		raw = EV_W'($urandom);
		return raw;
	endfunction

	task automatic push_ev(input pd_event_t ev, input crc_id_sel_t sel, input bit rep);
		queued_event_t it;
		it.ev = ev;
		it.id_sel = sel;
		it.rx_repeat = rep;
		event_q.push_back(it);
		queued_cnt++;
	endtask

	task automatic put_ctl(input cmd_t c, input bit sr_req, input bit ams, input bit crc,
		input bit bist, input bit more, input bit ok, input crc_id_sel_t sel);
		pd_event_t ev;
		ev = rand_event();
		ev.command = c;
		ev.soft_reset_request = sr_req;
		ev.ams_pending = ams;
		ev.expects_goodcrc = crc;
		ev.bist_active = bist;
		ev.bist_remaining = more;
		ev.response_ok = ok;
		push_ev(ev, sel, 1'b0);
	endtask

	task automatic put_rx(input logic [HDR_W-1:0] hdr, input bit sop, input bit sop_ok,
		input bit rep);
		pd_event_t ev;
		ev = rand_event();
		ev.command = CMD_RX_MESSAGE;
		ev.rx_header = hdr;
		ev.rx_sop_prime = sop;
		ev.sop_prime_expected = sop_ok;
		push_ev(ev, CRC_ID_RANDOM, rep);
	endtask

	task automatic gen_transmit();
		bit sr_req, ams, crc, bist, last_ok;
		int tries, more;
		sr_req = ($urandom_range(0, 9) == 0);
		ams = ($urandom_range(0, 11) == 0);
		crc = ($urandom_range(0, 4) != 0);
		put_ctl(CMD_TX_REQUEST, sr_req, ams, crc, rbit(), rbit(), rbit(), CRC_ID_RANDOM);
		if (ams)
			return;
		if (crc) begin
			tries = $urandom_range(0, 1) ? 1 : $urandom_range(2, 9);
			for (int k = 0; k < tries; k++) begin
				put_ctl(CMD_PHY_TX_DONE, rbit(), rbit(), rbit(), rbit(), rbit(),
					rbit(), CRC_ID_RANDOM);
				last_ok = (k == tries - 1) && ($urandom_range(0, 4) != 0);
				if (last_ok)
					put_ctl(CMD_PHY_RESP, rbit(), rbit(), rbit(), rbit(), rbit(),
						1'b1, CRC_ID_MATCH);
				else if ($urandom_range(0, 1))
					put_ctl(CMD_PHY_RESP, rbit(), rbit(), rbit(), rbit(), rbit(),
						1'b1, CRC_ID_STALE);
				else
					put_ctl(CMD_PHY_RESP, rbit(), rbit(), rbit(), rbit(), rbit(),
						1'b0, CRC_ID_RANDOM);
			end
		end else begin
			bist = rbit();
			more = bist ? $urandom_range(0, 3) : 0;
			repeat (more)
				put_ctl(CMD_PHY_TX_DONE, rbit(), rbit(), rbit(), 1'b1, 1'b1,
					rbit(), CRC_ID_RANDOM);
			put_ctl(CMD_PHY_TX_DONE, rbit(), rbit(), rbit(), bist, 1'b0,
				rbit(), CRC_ID_RANDOM);
		end
	endtask

	task automatic gen_receive();
		logic [HDR_W-1:0] hdr;
		hdr = HDR_W'($urandom);
		if ($urandom_range(0, 6) == 0)
			hdr = (hdr & ~HDR_SOFT_RESET_MASK) | HDR_SOFT_RESET_VAL;
		put_rx(hdr, $urandom_range(0, 3) == 0, rbit(), $urandom_range(0, 2) == 0);
	endtask

	task automatic random_block(input int n);
		int start;
		start = queued_cnt;
		while (queued_cnt - start < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: gen_transmit();
				6, 7: gen_receive();
				default: push_ev(rand_event(), CRC_ID_RANDOM, rbit());
			endcase
		end
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PD_REV2)
			m_rev2 = val[0];
		else
			m_retry_cfg = val;
	endtask

	task automatic wait_idle();
		while (event_q.size() != 0 || in_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	initial begin : stimulus
		int plan_rev [N_PLAN];
		int plan_cnt [N_PLAN];
		plan_rev = '{1, 0, 0, 1, 0, 1};
		plan_cnt = '{7, 1, 0, 1, 7, 0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset settings (rev 3.0, retry limit 2)
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 1, 1, 1, 1, CRC_ID_RANDOM);   // wrong phase
		put_ctl(CMD_PHY_RESP, 0, 0, 1, 0, 0, 1, CRC_ID_MATCH);       // wrong phase
		put_ctl(CMD_TX_REQUEST, 1, 0, 1, 0, 0, 0, CRC_ID_RANDOM);
		put_ctl(CMD_TX_REQUEST, 0, 0, 1, 0, 0, 0, CRC_ID_RANDOM);    // busy, ignored
		put_ctl(CMD_PHY_RESP, 0, 0, 1, 0, 0, 1, CRC_ID_MATCH);       // early, ignored
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 0, 0, 0, 0, CRC_ID_RANDOM);
		put_ctl(CMD_PHY_RESP, 0, 0, 0, 0, 0, 1, CRC_ID_MATCH);
		// retries exhausted: stale ID, then two timeouts
		put_ctl(CMD_TX_REQUEST, 0, 0, 1, 0, 0, 0, CRC_ID_RANDOM);
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 0, 0, 0, 0, CRC_ID_RANDOM);
		put_ctl(CMD_PHY_RESP, 0, 0, 0, 0, 0, 1, CRC_ID_STALE);
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 0, 0, 0, 0, CRC_ID_RANDOM);
		put_ctl(CMD_PHY_RESP, 0, 0, 0, 0, 0, 0, CRC_ID_MATCH);
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 0, 0, 0, 0, CRC_ID_RANDOM);
		put_ctl(CMD_PHY_RESP, 0, 0, 0, 0, 0, 0, CRC_ID_RANDOM);
		// soft reset with collision avoidance pending
		put_ctl(CMD_TX_REQUEST, 1, 1, 1, 0, 0, 0, CRC_ID_RANDOM);
		// BIST carrier, no GoodCRC
		put_ctl(CMD_TX_REQUEST, 0, 0, 0, 1, 1, 0, CRC_ID_RANDOM);
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 0, 1, 1, 0, CRC_ID_RANDOM);
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 0, 1, 0, 0, CRC_ID_RANDOM);
		put_ctl(CMD_TX_REQUEST, 0, 0, 0, 0, 0, 0, CRC_ID_RANDOM);
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 0, 0, 1, 0, CRC_ID_RANDOM);
		// receive: rejected SOP', new, duplicate, soft reset header
		put_rx(16'hFFFF, 1, 0, 0);
		put_rx(16'hFFFF, 0, 0, 0);
		put_rx(16'hFFFF, 1, 1, 0);
		put_rx(16'h0E0D, 0, 1, 0);
		// reception aborts a pending transmit
		put_ctl(CMD_TX_REQUEST, 0, 0, 1, 0, 0, 0, CRC_ID_RANDOM);
		put_rx(16'h0000, 1, 1, 0);
		put_ctl(CMD_PHY_TX_DONE, 0, 0, 0, 0, 0, 0, CRC_ID_RANDOM);
		wait_idle();

		for (int p = 0; p < N_PLAN; p++) begin
			write_cfg(CFG_PD_REV2, CFG_DATA_W'(plan_rev[p]));
			write_cfg(CFG_RETRY_COUNT, CFG_DATA_W'(plan_cnt[p]));
			no_idle = (p == 1);
			random_block(PER_PHASE);
			wait_idle();
		end
		no_idle = 1'b0;

		if (outcome_q.size() != 0)
			report_mismatch($sformatf("%0d outcomes never arrived", outcome_q.size()));
		$display("%0d event beats over %0d retry settings: %0d acked, %0d retries, %0d errors",
			queued_cnt, N_PLAN + 1, n_sent, n_retx, n_err);
		$display("%0d receptions taken, %0d duplicates dropped, %0d mismatches",
			n_rcvd, n_dup, fail_cnt);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/pdpl_pkg.sv
rtl/pdpl_step.sv
rtl/pd_protocol_layer_tx_rx.sv
bench/tb_pd_protocol_layer_tx_rx.sv
